/* rtl/core/mss_pkg.sv */
// Shared types and constants for the maximum submatrix sum block.
package mss_pkg;

    localparam int BEST_W = 28;
    localparam int CFG_W  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_SIZE_N = 1'b0;

    localparam int SIZE_W     = 7;
    localparam int SIZE_RESET = 1;

    typedef struct packed {
        logic valid;
        logic first;
        logic clear;
    } kad_ctl_t;

endpackage

/* rtl/core/mss_kadane.sv */
// Kadane running-sum and best-sum tracker over a stream of column strip sums.
module mss_kadane import mss_pkg::*; #(
    parameter int SUM_W   = 31,
    parameter int STRIP_W = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  kad_ctl_t                  ctl,
    input  logic signed [STRIP_W-1:0] strip,
    output logic [BEST_W-1:0]         best_sum
);

    localparam int CMP_W = (SUM_W > BEST_W + 1) ? SUM_W : BEST_W + 1;

    logic signed [SUM_W-1:0] run_reg;
    logic signed [SUM_W-1:0] run_next;
    logic                    run_valid_reg;
    logic signed [SUM_W-1:0] best_reg;
    logic signed [SUM_W-1:0] strip_ext;
    logic signed [CMP_W-1:0] best_ext;
    logic signed [CMP_W-1:0] best_max;

    assign strip_ext = SUM_W'(strip);

    always_comb begin
        if (ctl.first || run_reg <= 0) begin
            run_next = strip_ext;
        end else begin
            run_next = run_reg + strip_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
            run_reg       <= '0;
            best_reg      <= '0;
        end else begin
            run_valid_reg <= ctl.valid;
            if (ctl.valid) begin
                run_reg <= run_next;
            end
            if (ctl.clear) begin
                best_reg <= '0;
            end else if (run_valid_reg && run_reg > best_reg) begin
                best_reg <= run_reg;
            end
        end
    end

    // saturate at the output width
    assign best_ext = CMP_W'(best_reg);
    assign best_max = CMP_W'({BEST_W{1'b1}});
    assign best_sum = (best_ext > best_max) ? {BEST_W{1'b1}} : best_ext[BEST_W-1:0];

endmodule

/* rtl/core/max_submatrix_sum.sv */
// Top level of the maximum submatrix sum block: loader, prefix memory, scan sequencer.
//
// Usage: write size_n (side length, 1..MAX_N; 0 acts as 1, larger values clamp
// to MAX_N) over the APB port at address 0; the write also restarts loading.
// Then stream the n*n elements in row-major order on the s_ channel, one per
// transfer, one transfer per cycle. Column prefix sums go into an internal RAM
// with two read ports and one write port.
// After the last element the block stops taking input and scans every pair of
// top and bottom rows, one column per cycle through the RAM read ports, and then
// drains its pipeline. The loader takes no element of the next matrix until the
// scan is done and its result has gone into the output register.
// One result transfer, the largest submatrix sum (0 if all are negative),
// is then offered on the m_ channel from an output register; loading of the
// next matrix proceeds while it waits. If the receiver still stalls when the
// next scan finishes, the block holds that result until the register frees.
// Reset (synchronous, aresetn low) sets size_n to 1, drops any partial matrix
// and any pending result. The RAM is not cleared: each entry is written
// before it is read within every matrix.
module max_submatrix_sum import mss_pkg::*; #(
    parameter int MAX_N     = 64,
    parameter int ELEM_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: [ELEM_BITS-1:0] element_value, rest zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((ELEM_BITS + 7) / 8) * 8-1:0] s_tdata,
    // m_tdata: [27:0] best_sum, [31:28] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [CFG_W-1:0]                    pwdata,
    output logic [CFG_W-1:0]                    prdata,
    output logic                                pready
);

    localparam int IDX_W   = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NW      = $clog2(MAX_N + 1);
    localparam int DEPTH   = MAX_N * MAX_N;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PREF_W  = ELEM_BITS + IDX_W + 1;
    localparam int STRIP_W = PREF_W + 1;
    localparam int SUM_W   = STRIP_W + IDX_W + 1;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_LAST = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]               state_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [NW-1:0]            n_eff;
    logic [IDX_W-1:0]         nm1;

    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_reg;
    logic                     ld_valid_reg;
    logic                     ld_row0_reg;
    logic [ADDR_W-1:0]        ld_addr_reg;
    logic signed [ELEM_BITS-1:0] ld_elem_reg;
    logic signed [PREF_W-1:0] wr_data;

    logic [IDX_W-1:0]         top_reg;
    logic [IDX_W-1:0]         bot_reg;
    logic [IDX_W-1:0]         sc_col_reg;
    logic                     iss_reg;
    logic                     p1_reg;
    logic                     p1_top0_reg;
    logic                     p1_first_reg;
    logic                     p2_reg;
    logic                     p2_first_reg;
    logic                     p3_reg;
    logic signed [STRIP_W-1:0] strip_reg;
    logic signed [STRIP_W-1:0] strip_next;

    logic                     m_valid_reg;
    logic [BEST_W-1:0]        m_data_reg;
    logic [BEST_W-1:0]        best_sum;

    logic signed [PREF_W-1:0] mem [DEPTH];
    logic signed [PREF_W-1:0] rd_a_reg;
    logic signed [PREF_W-1:0] rd_b_reg;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        addr_b;

    logic                     s_acc;
    logic                     cfg_wr;
    logic                     last_col;
    logic                     last_row;
    logic                     sc_last_col;
    kad_ctl_t                 kad_ctl;

    function automatic logic [ADDR_W-1:0] ent_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        ent_addr = ADDR_W'(r) * ADDR_W'(MAX_N) + ADDR_W'(c);
    endfunction

    always_comb begin
        if (size_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(size_reg) > MAX_N) begin
            n_eff = NW'(MAX_N);
        end else begin
            n_eff = NW'(size_reg);
        end
    end
    assign nm1 = IDX_W'(n_eff - 1'b1);

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_SIZE_N);
    assign prdata   = (paddr[2] == REG_SIZE_N) ? CFG_W'(size_reg) : '0;
    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 32'(m_data_reg);

    assign last_col    = (col_reg == nm1);
    assign last_row    = (row_reg == nm1);
    assign sc_last_col = (sc_col_reg == nm1);

    always_comb begin
        if (state_reg == ST_SCAN) begin
            addr_a = ent_addr(bot_reg, sc_col_reg);
            addr_b = (top_reg == '0) ? '0 : ent_addr(top_reg - 1'b1, sc_col_reg);
        end else begin
            addr_a = (row_reg == '0) ? '0 : ent_addr(row_reg - 1'b1, col_reg);
            addr_b = '0;
        end
    end

    assign wr_data    = PREF_W'(ld_elem_reg) + (ld_row0_reg ? PREF_W'(0) : rd_a_reg);
    assign strip_next = STRIP_W'(rd_a_reg) - (p1_top0_reg ? STRIP_W'(0) : STRIP_W'(rd_b_reg));

    // prefix RAM: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (ld_valid_reg) begin
            mem[ld_addr_reg] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            ld_elem_reg <= s_tdata[ELEM_BITS-1:0];
            ld_row0_reg <= (row_reg == '0);
            ld_addr_reg <= ent_addr(row_reg, col_reg);
        end
        p1_top0_reg  <= (top_reg == '0);
        p1_first_reg <= (sc_col_reg == '0);
        p2_first_reg <= p1_first_reg;
        strip_reg    <= strip_next;
        if (state_reg == ST_EMIT && (!m_valid_reg || m_tready)) begin
            m_data_reg <= best_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            size_reg     <= SIZE_W'(SIZE_RESET);
            row_reg      <= '0;
            col_reg      <= '0;
            ld_valid_reg <= 1'b0;
            top_reg      <= '0;
            bot_reg      <= '0;
            sc_col_reg   <= '0;
            iss_reg      <= 1'b0;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            p3_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            ld_valid_reg <= s_acc;
            p1_reg       <= iss_reg;
            p2_reg       <= p1_reg;
            p3_reg       <= p2_reg;
            if (m_valid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                size_reg <= pwdata[SIZE_W-1:0];
            end

            case (state_reg)
                ST_LOAD: begin
                    if (cfg_wr) begin
                        row_reg <= '0;
                        col_reg <= '0;
                    end else if (s_acc) begin
                        if (last_col) begin
                            col_reg <= '0;
                            if (last_row) begin
                                row_reg   <= '0;
                                state_reg <= ST_LAST;
                            end else begin
                                row_reg <= row_reg + 1'b1;
                            end
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                ST_LAST: begin
                    // last prefix write lands this cycle
                    top_reg    <= '0;
                    bot_reg    <= '0;
                    sc_col_reg <= '0;
                    iss_reg    <= 1'b1;
                    state_reg  <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (iss_reg) begin
                        if (sc_last_col) begin
                            sc_col_reg <= '0;
                            if (bot_reg == nm1) begin
                                if (top_reg == nm1) begin
                                    iss_reg <= 1'b0;
                                end else begin
                                    top_reg <= top_reg + 1'b1;
                                    bot_reg <= top_reg + 1'b1;
                                end
                            end else begin
                                bot_reg <= bot_reg + 1'b1;
                            end
                        end else begin
                            sc_col_reg <= sc_col_reg + 1'b1;
                        end
                    end else if (!p1_reg && !p2_reg && !p3_reg) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign kad_ctl.valid = p2_reg;
    assign kad_ctl.first = p2_first_reg;
    assign kad_ctl.clear = (state_reg == ST_LAST);

    mss_kadane #(
        .SUM_W   (SUM_W),
        .STRIP_W (STRIP_W)
    ) u_kadane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (kad_ctl),
        .strip    (strip_reg),
        .best_sum (best_sum)
    );

`ifndef SYNTHESIS
    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside emit state");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !ld_valid_reg)
        else $error("prefix write pending during scan");

    a_load_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> (row_reg <= nm1) && (col_reg <= nm1))
        else $error("load position beyond matrix side");

    a_drain_before_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> !iss_reg && !p1_reg && !p2_reg && !p3_reg)
        else $error("scan pipeline busy in emit state");
`endif

endmodule

/* dv/mss_sum_checker.sv */
// Checker for max_submatrix_sum: tracks size_n, predicts each matrix's best sum, compares.
module mss_sum_checker import mss_pkg::*; #(
    parameter int MAX_N     = 64,
    parameter int ELEM_BITS = 16,
    parameter int DATA_W    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [31:0]       m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [CFG_W-1:0]  pwdata,
    input  logic [CFG_W-1:0]  prdata,
    input  logic              pready,
    output int                pending,
    output int                fail_count
);

    localparam longint SUM_CAP = (longint'(1) << BEST_W) - 1;

    longint            col_prefix [MAX_N*MAX_N];
    logic [SIZE_W-1:0] size_reg = SIZE_W'(SIZE_RESET);
    int                load_cnt = 0;
    int                err_cnt  = 0;
    logic [BEST_W-1:0] best_sum_q [$];

    function automatic int side_of(logic [SIZE_W-1:0] sz);
        if (sz == 0) return 1;
        if (sz > MAX_N) return MAX_N;
        return int'(sz);
    endfunction

    // 2D Kadane over every top/bottom row pair, strips from column prefixes
    function automatic longint best_submatrix(int n);
        longint best, run, strip;
        best = 0;
        for (int r0 = 0; r0 < n; r0++) begin
            for (int r1 = r0; r1 < n; r1++) begin
                run = 0;
                for (int c = 0; c < n; c++) begin
                    strip = col_prefix[r1*MAX_N + c];
                    if (r0 > 0) strip -= col_prefix[(r0-1)*MAX_N + c];
                    run = (run > 0) ? run + strip : strip;
                    if (run > best) best = run;
                end
            end
        end
        return (best > SUM_CAP) ? SUM_CAP : best;
    endfunction

    function automatic void load_element(logic [ELEM_BITS-1:0] raw);
        int     n, r, c;
        longint v;
        n = side_of(size_reg);
        if (load_cnt >= n*n) load_cnt = 0;
        r = load_cnt / n;
        c = load_cnt % n;
        v = longint'($signed(raw));
        if (r > 0) v += col_prefix[(r-1)*MAX_N + c];
        col_prefix[r*MAX_N + c] = v;
        load_cnt++;
        if (load_cnt == n*n) begin
            best_sum_q.push_back(BEST_W'(best_submatrix(n)));
            load_cnt = 0;
        end
    endfunction

    always @(posedge aclk) begin
        logic [BEST_W-1:0] want;
        if (!aresetn) begin
            size_reg = SIZE_W'(SIZE_RESET);
            load_cnt = 0;
            best_sum_q.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_SIZE_N) begin
                        size_reg = pwdata[SIZE_W-1:0];
                        load_cnt = 0;
                    end
                end else if (paddr[2] == REG_SIZE_N && prdata !== CFG_W'(size_reg)) begin
                    $error("size_n: expected %0d, actual %0d", size_reg, prdata);
                    err_cnt++;
                end
            end
            // result side first: a result can only match an older matrix
            if (m_tvalid && m_tready) begin
                if (best_sum_q.size() == 0) begin
                    $error("best_sum: expected none, actual %0d", m_tdata[BEST_W-1:0]);
                    err_cnt++;
                end else begin
                    want = best_sum_q.pop_front();
                    if (m_tdata[BEST_W-1:0] !== want) begin
                        $error("best_sum: expected %0d, actual %0d",
                               want, m_tdata[BEST_W-1:0]);
                        err_cnt++;
                    end
                    if (m_tdata[31:BEST_W] !== '0) begin
                        $error("m_tdata pad: expected 0, actual %0h", m_tdata[31:BEST_W]);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) load_element(s_tdata[ELEM_BITS-1:0]);
        end
        pending    <= best_sum_q.size();
        fail_count <= err_cnt;
    end

endmodule

/* dv/tb_top.sv */
// Testbench top for max_submatrix_sum: clock, reset, stimulus, ready pattern and verdict.
module tb_top;
    import mss_pkg::*;

    localparam int MAX_N       = 64;
    localparam int ELEM_BITS   = 16;
    localparam int DATA_W      = ((ELEM_BITS + 7) / 8) * 8;
    localparam int STALL_LIMIT = 600000;

    localparam logic [2:0]        ADDR_SIZE_N = {REG_SIZE_N, 2'b00};
    localparam logic [2:0]        ADDR_UNUSED = {~REG_SIZE_N, 2'b00};
    localparam logic [DATA_W-1:0] ELEM_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] ELEM_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum int {FILL_ANY, FILL_NEAR_ZERO, FILL_NEGATIVE, FILL_EXTREME} fill_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [2:0]        paddr    = '0;
    logic [CFG_W-1:0]  pwdata   = '0;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    int tx_idle   = 17;
    int rx_idle   = 80;
    int stall_cnt = 0;
    int pending;
    int fail_count;

    max_submatrix_sum #(.MAX_N(MAX_N), .ELEM_BITS(ELEM_BITS)) uut (.*);

    mss_sum_checker #(.MAX_N(MAX_N), .ELEM_BITS(ELEM_BITS), .DATA_W(DATA_W)) sum_check (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) m_tready <= aresetn && ($urandom_range(99) >= rx_idle);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cnt <= 0;
        end else if (stall_cnt == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic push_element(input logic [DATA_W-1:0] elem);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= elem;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // hold the input until every pending result is out, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // junk in the unused upper bits of pwdata
    task automatic write_size(input logic [SIZE_W-1:0] sz);
        logic [CFG_W-1:0] word;
        word = $urandom();
        word[SIZE_W-1:0] = sz;
        apb_write(ADDR_SIZE_N, word);
        apb_read(ADDR_SIZE_N);
    endtask

    function automatic logic [DATA_W-1:0] pick_element(fill_t mode);
        case (mode)
            FILL_NEAR_ZERO: return DATA_W'($urandom_range(100) - 50);
            FILL_NEGATIVE: begin
                if ($urandom_range(9) == 0) return DATA_W'($urandom_range(40));
                return DATA_W'(-int'($urandom_range(32768, 1)));
            end
            FILL_EXTREME: begin
                case ($urandom_range(4))
                    0: return ELEM_MAX;
                    1: return ELEM_MIN;
                    2: return '0;
                    3: return '1;
                    default: return DATA_W'(1);
                endcase
            end
            default: return DATA_W'($urandom());
        endcase
    endfunction

    task automatic run_phase(input int tx, input int rx, input int quota);
        int                sent;
        int                n;
        int                mats;
        int                len;
        int                pick;
        logic [SIZE_W-1:0] sz;
        fill_t             mode;
        tx_idle = tx;
        rx_idle = rx;
        sent = 0;
        while (sent < quota) begin
            wait_idle();
            pick = $urandom_range(99);
            if (pick < 5)       sz = '0;
            else if (pick < 70) sz = SIZE_W'($urandom_range(6, 1));
            else if (pick < 95) sz = SIZE_W'($urandom_range(12, 7));
            else                sz = SIZE_W'($urandom_range(20, 13));
            write_size(sz);
            if ($urandom_range(9) == 0) apb_write(ADDR_UNUSED, $urandom());
            n = (sz == 0) ? 1 : int'(sz);
            mats = $urandom_range(3, 1);
            for (int k = 0; k < mats; k++) begin
                mode = fill_t'($urandom_range(3));
                len = n * n;
                // a dropped partial matrix now and then
                if (k == mats - 1 && $urandom_range(9) == 0) len = $urandom_range(n*n - 1);
                for (int i = 0; i < len; i++) push_element(pick_element(mode));
                sent += len;
                if ($urandom_range(4) == 0) wait_idle();
            end
        end
    endtask

    initial begin
        int sq_a [4] = '{5, -3, -2, 4};
        int sq_b [4] = '{-1, -2, -3, -4};
        int sq_c [9] = '{-5, 6, -1, 2, 7, -9, -8, 3, 4};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // size 0 acts as 1: each element is its own matrix
        write_size('0);
        push_element(ELEM_MAX);
        push_element(ELEM_MIN);
        push_element('0);
        push_element(DATA_W'(1));
        wait_idle();

        // partial matrix dropped by a size rewrite
        write_size(SIZE_W'(2));
        push_element(DATA_W'(7));
        push_element(DATA_W'(-9));
        wait_idle();
        write_size(SIZE_W'(2));
        foreach (sq_a[i]) push_element(DATA_W'(sq_a[i]));
        wait_idle();

        // write to an unused register must not touch size_n; all negative gives 0
        apb_write(ADDR_UNUSED, CFG_W'(5));
        apb_read(ADDR_SIZE_N);
        foreach (sq_b[i]) push_element(DATA_W'(sq_b[i]));
        wait_idle();

        write_size(SIZE_W'(3));
        foreach (sq_c[i]) push_element(DATA_W'(sq_c[i]));

        run_phase(17, 80, 300);
        run_phase(80, 17, 300);

        // largest side, then an oversize write that clamps; each load is
        // dropped part way by the next size write
        tx_idle = 0;
        rx_idle = 0;
        wait_idle();
        write_size(SIZE_W'(MAX_N));
        repeat (MAX_N + 1) push_element(ELEM_MAX);
        wait_idle();
        write_size('1);
        repeat (MAX_N + 1) push_element(pick_element(FILL_ANY));
        run_phase(0, 0, 260);

        wait_idle();
        repeat (16) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/mss_pkg.sv
rtl/core/mss_kadane.sv
rtl/core/max_submatrix_sum.sv
dv/mss_sum_checker.sv
dv/tb_top.sv
